/* hdl/sru_pkg.sv */
// ---------------------------------------------------------------------------
// sru_pkg
// Shared types and constants of the sort-unique block.
// ---------------------------------------------------------------------------
`default_nettype none

package sru_pkg;

  localparam int DATA_W        = 32;
  localparam int CNT_W         = 7;
  localparam int MAX_ITEMS_DEF = 64;
  localparam logic [CNT_W-1:0] DROP_LIMIT = 7'd64;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic                     last_in;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] sorted_value;
    logic                     last_out;
    logic [CNT_W-1:0]         ignored_count;
  } out_item_t;

  typedef struct packed {
    logic gt;
    logic eq;
  } cmp_res_t;

  typedef enum logic [2:0] {
    ST_FILL,
    ST_LOAD,
    ST_LOADW,
    ST_CMP,
    ST_EMIT
  } state_t;

endpackage

`default_nettype wire

/* hdl/sru_ram.sv */
// ---------------------------------------------------------------------------
// sru_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module sru_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

/* hdl/sru_cmp.sv */
// ---------------------------------------------------------------------------
// sru_cmp
// Shared signed compare unit: greater-than and equality.
// ---------------------------------------------------------------------------
`default_nettype none

module sru_cmp (
  input  wire logic signed [sru_pkg::DATA_W-1:0] a,
  input  wire logic signed [sru_pkg::DATA_W-1:0] b,
  output sru_pkg::cmp_res_t                      res
);

  always_comb begin
    res.gt = (a > b);
    res.eq = (a == b);
  end

endmodule

`default_nettype wire

/* hdl/sort_and_remove_duplicates.sv */
// ---------------------------------------------------------------------------
// sort_and_remove_duplicates
// Collects a set of signed values, sorts it and emits each distinct value.
// ---------------------------------------------------------------------------
// Input items (in_item) are appended to a RAM in arrival order, one per cycle
// while the block is collecting. Up to MAX_ITEMS values are kept; further
// values of the set are dropped and counted (saturating at 64). An item with
// last_in set closes the set and starts the sort; in_ready is low until the
// whole set has been emitted.
// The sort runs one compare-swap per cycle on a single shared comparator:
// row i takes (count - i - 1) compares plus its load, load-wait and emit steps.
// Each row ends with the next smallest value, which goes to the output
// register if it differs from the previous one. last_out marks the largest
// kept value of the set; ignored_count carries the drop count of the set.
// The output register lets the next set start filling while the final result
// waits. A stalled receiver pauses the sort at the emit step.
// Reset clears the fill and drop counts, the sequencer and out_valid.
// ---------------------------------------------------------------------------
`default_nettype none

module sort_and_remove_duplicates #(
  parameter int MAX_ITEMS = sru_pkg::MAX_ITEMS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire sru_pkg::in_item_t  in_item,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output sru_pkg::out_item_t      out_item
);

  localparam int AW = $clog2(MAX_ITEMS);
  localparam int CW = $clog2(MAX_ITEMS + 1);
  localparam logic [CW-1:0] CNT_MAX = CW'(MAX_ITEMS);

  sru_pkg::state_t                      state_r, state_nxt;
  logic [CW-1:0]                        cnt_r, cnt_nxt;
  logic [sru_pkg::CNT_W-1:0]            drop_r, drop_nxt;
  logic signed [sru_pkg::DATA_W-1:0]    max_r, max_nxt;
  logic signed [sru_pkg::DATA_W-1:0]    cur_r, cur_nxt;
  logic signed [sru_pkg::DATA_W-1:0]    prev_r, prev_nxt;
  logic [AW-1:0]                        i_r, i_nxt;
  logic [AW-1:0]                        j_r, j_nxt;
  sru_pkg::out_item_t                   out_r, out_nxt;
  logic                                 out_valid_r, out_valid_nxt;

  logic                                 mem_we;
  logic [AW-1:0]                        mem_waddr;
  logic [AW-1:0]                        mem_raddr;
  logic [sru_pkg::DATA_W-1:0]           mem_wdata;
  logic [sru_pkg::DATA_W-1:0]           mem_rdata;
  logic signed [sru_pkg::DATA_W-1:0]    rd_val;
  logic signed [sru_pkg::DATA_W-1:0]    cmp_a, cmp_b;
  sru_pkg::cmp_res_t                    cmp_res;
  logic                                 emit;
  logic                                 out_free;

  sru_ram #(
    .WIDTH(sru_pkg::DATA_W),
    .DEPTH(MAX_ITEMS)
  ) u_store (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  sru_cmp u_cmp (
    .a  (cmp_a),
    .b  (cmp_b),
    .res(cmp_res)
  );

  assign rd_val   = $signed(mem_rdata);
  assign out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sru_pkg::ST_FILL;
      cnt_r       <= '0;
      drop_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      drop_r      <= drop_nxt;
      out_valid_r <= out_valid_nxt;
    end
    max_r  <= max_nxt;
    cur_r  <= cur_nxt;
    prev_r <= prev_nxt;
    i_r    <= i_nxt;
    j_r    <= j_nxt;
    out_r  <= out_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    drop_nxt      = drop_r;
    max_nxt       = max_r;
    cur_nxt       = cur_r;
    prev_nxt      = prev_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    in_ready      = 1'b0;
    mem_we        = 1'b0;
    mem_waddr     = cnt_r[AW-1:0];
    mem_wdata     = in_item.value;
    mem_raddr     = i_r;
    cmp_a         = cur_r;
    cmp_b         = rd_val;
    emit          = 1'b0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      sru_pkg::ST_FILL: begin
        in_ready = 1'b1;
        cmp_a    = in_item.value;
        cmp_b    = max_r;
        if (in_valid) begin
          if (cnt_r < CNT_MAX) begin
            mem_we  = 1'b1;
            cnt_nxt = cnt_r + CW'(1);
            if (cnt_r == '0 || cmp_res.gt) begin
              max_nxt = in_item.value;
            end
          end else if (drop_r < sru_pkg::DROP_LIMIT) begin
            drop_nxt = drop_r + sru_pkg::CNT_W'(1);
          end
          if (in_item.last_in) begin
            i_nxt     = '0;
            state_nxt = sru_pkg::ST_LOAD;
          end
        end
      end
      sru_pkg::ST_LOAD: begin
        mem_raddr = i_r;
        state_nxt = sru_pkg::ST_LOADW;
      end
      sru_pkg::ST_LOADW: begin
        cur_nxt   = rd_val;
        j_nxt     = i_r + AW'(1);
        mem_raddr = i_r + AW'(1);
        if (CW'(i_r) + CW'(1) < cnt_r) begin
          state_nxt = sru_pkg::ST_CMP;
        end else begin
          state_nxt = sru_pkg::ST_EMIT;
        end
      end
      sru_pkg::ST_CMP: begin
        if (cmp_res.gt) begin
          mem_we    = 1'b1;
          mem_waddr = j_r;
          mem_wdata = cur_r;
          cur_nxt   = rd_val;
        end
        j_nxt     = j_r + AW'(1);
        mem_raddr = j_r + AW'(1);
        if (!(CW'(j_r) + CW'(1) < cnt_r)) begin
          state_nxt = sru_pkg::ST_EMIT;
        end
      end
      sru_pkg::ST_EMIT: begin
        cmp_b = prev_r;
        emit  = (i_r == '0) || !cmp_res.eq;
        if (!emit || out_free) begin
          if (emit) begin
            out_valid_nxt         = 1'b1;
            out_nxt.sorted_value  = cur_r;
            out_nxt.last_out      = (cur_r == max_r);
            out_nxt.ignored_count = drop_r;
          end
          prev_nxt = cur_r;
          if (CW'(i_r) + CW'(1) == cnt_r) begin
            cnt_nxt   = '0;
            drop_nxt  = '0;
            state_nxt = sru_pkg::ST_FILL;
          end else begin
            i_nxt     = i_r + AW'(1);
            state_nxt = sru_pkg::ST_LOAD;
          end
        end
      end
      default: begin
        state_nxt = sru_pkg::ST_FILL;
      end
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_MAX)
    else $error("fill count above store depth");

  a_drop_bound: assert property (@(posedge clk) disable iff (!rst_n)
    drop_r <= sru_pkg::DROP_LIMIT)
    else $error("drop count above limit");

  a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
    (drop_r != '0) |-> (cnt_r == CNT_MAX))
    else $error("values dropped while store not full");

  a_set_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == sru_pkg::ST_EMIT && state_nxt == sru_pkg::ST_FILL)
      |=> (cnt_r == '0 && drop_r == '0))
    else $error("counts not cleared after set");

  a_cmp_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == sru_pkg::ST_CMP) |-> (j_r > i_r && CW'(j_r) < cnt_r))
    else $error("compare index out of row");

endmodule

`default_nettype wire
